FILE: sv/tilt_pkg.sv
// tilt_pkg: constants shared by the tilt angle pipeline.
// No dependencies.
package tilt_pkg;

    localparam int ACCEL_W = 16;
    localparam int ANGLE_W = 16;
    localparam int RAD_W   = 34;
    localparam int SQ_W    = 32;
    localparam int ROOT_W  = 33;
    localparam int CV_W    = 38;

    localparam logic [RAD_W-1:0] RAD_HALF_PI = 34'd1686629713;
    localparam logic [RAD_W-1:0] RAD_PI      = 34'd3373259426;

    function automatic logic [RAD_W-1:0] atan_step(input int i);
        logic [RAD_W-1:0] r;
        r = '0;
        case (i)
            0: r = 34'd843314856;
            1: r = 34'd497837829;
            2: r = 34'd263043836;
            3: r = 34'd133525158;
            4: r = 34'd67021686;
            5: r = 34'd33543515;
            6: r = 34'd16775850;
            7: r = 34'd8388437;
            8: r = 34'd4194282;
            9: r = 34'd2097149;
            default:
            begin
                if (i < 30)
                    r = (34'd1 << (30 - i)) - 34'd1;
                else
                    r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

FILE: sv/accel_tilt_angles.sv
// accel_tilt_angles: top level, three axis angle pipelines plus sign and wrap stage.
// Depends on tilt_pkg and tilt_axis.
//
// Takes one sample per cycle while in_stall is low and returns one beat of three tilt
// angles per sample. Stages in order: 1 square stage, 33 square root stages, 1 load
// stage, CORDIC_STEPS CORDIC stages, 4 scale stages and 1 output stage; a stall on the
// output freezes the whole pipeline, so throughput is one beat per cycle only while
// out_stall is low.
module accel_tilt_angles #(
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [tilt_pkg::ACCEL_W-1:0]  accel_x,
    input  logic signed [tilt_pkg::ACCEL_W-1:0]  accel_y,
    input  logic signed [tilt_pkg::ACCEL_W-1:0]  accel_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [tilt_pkg::ANGLE_W-1:0]  tilt_x,
    output logic signed [tilt_pkg::ANGLE_W-1:0]  tilt_y,
    output logic signed [tilt_pkg::ANGLE_W-1:0]  tilt_z,
    output logic                                 zero_vector
);
    localparam int AW  = ANGLE_FRAC_BITS + 9;
    localparam int LAT = 1 + tilt_pkg::ROOT_W + 1 + CORDIC_STEPS + 4;
    localparam int SW  = AW + 2;

    logic adv;
    logic z_sign_mode_reg;
    logic [LAT-1:0] v_reg;
    logic [LAT-1:0] zero_reg;
    logic [LAT-1:0] zneg_reg;

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            z_sign_mode_reg <= 1'b0;
        else if (cfg_we)
            z_sign_mode_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero_reg <= {zero_reg[LAT-2:0], (accel_x == 0 && accel_y == 0 && accel_z == 0)};
            zneg_reg <= {zneg_reg[LAT-2:0], accel_z[tilt_pkg::ACCEL_W-1]};
        end
    end

    logic [AW-1:0] ax_ang, ay_ang, az_ang;

    tilt_axis #(.FRAC(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS)) u_ax (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .c(accel_x), .o1(accel_y), .o2(accel_z), .angle(ax_ang));
    tilt_axis #(.FRAC(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS)) u_ay (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .c(accel_y), .o1(accel_x), .o2(accel_z), .angle(ay_ang));
    tilt_axis #(.FRAC(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS)) u_az (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .c(accel_z), .o1(accel_x), .o2(accel_y), .angle(az_ang));

    localparam logic signed [SW-1:0] QUARTER = SW'(90) <<< ANGLE_FRAC_BITS;
    localparam logic signed [SW-1:0] HALF    = SW'(180) <<< ANGLE_FRAC_BITS;
    localparam logic signed [SW-1:0] FULL    = SW'(360) <<< ANGLE_FRAC_BITS;

    logic signed [SW-1:0] sx, sy, sz, tx, ty, tz;
    logic                 zn, zv;

    assign zn = zneg_reg[LAT-1];
    assign zv = zero_reg[LAT-1];

    always_comb
    begin
        sx = zn ? -SW'($signed({1'b0, ax_ang})) : SW'($signed({1'b0, ax_ang}));
        sy = zn ? -SW'($signed({1'b0, ay_ang})) : SW'($signed({1'b0, ay_ang}));
        sz = SW'($signed({1'b0, az_ang}));
        tx = sx - QUARTER;
        if (tx < -HALF)
            tx = tx + FULL;
        ty = sy - QUARTER;
        if (ty < -HALF)
            ty = ty + FULL;
        tz = (z_sign_mode_reg && tx < 0) ? -sz : sz;
        if (zv)
        begin
            tx = '0;
            ty = '0;
            tz = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (adv)
            out_valid <= v_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tilt_x      <= tilt_pkg::ANGLE_W'(tx);
            tilt_y      <= tilt_pkg::ANGLE_W'(ty);
            tilt_z      <= tilt_pkg::ANGLE_W'(tz);
            zero_vector <= zv;
        end
    end
endmodule

FILE: sv/tilt_axis.sv
// tilt_axis: pipelined acos(c/R) for one axis, result in degrees with FRAC fraction bits.
// Depends on tilt_pkg. Square root one bit per stage, CORDIC one step per stage.
module tilt_axis #(
    parameter int FRAC  = 7,
    parameter int STEPS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic signed [tilt_pkg::ACCEL_W-1:0]   c,
    input  logic signed [tilt_pkg::ACCEL_W-1:0]   o1,
    input  logic signed [tilt_pkg::ACCEL_W-1:0]   o2,
    output logic        [FRAC+8:0]                angle
);
    localparam int RB    = tilt_pkg::ROOT_W;       // root bits
    localparam int RW    = 2 * RB;                 // remainder width
    localparam int CW    = tilt_pkg::CV_W;
    localparam int ZW    = tilt_pkg::RAD_W + 2;
    localparam int SHMAX = CW - 1;
    localparam int MW    = 50;
    localparam int AW    = FRAC + 9;
    localparam int TW    = MW + FRAC - 32;
    localparam logic [28:0] RECIP25 = 29'd171798692;  // ceil(2^32 / 25)

    // stage 0: squares
    logic [tilt_pkg::SQ_W-1:0]           sq_reg;
    logic signed [tilt_pkg::ACCEL_W-1:0] c0_reg;
    logic signed [tilt_pkg::SQ_W-1:0]    o1_sq;
    logic signed [tilt_pkg::SQ_W-1:0]    o2_sq;

    assign o1_sq = o1 * o1;
    assign o2_sq = o2 * o2;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg <= $unsigned(o1_sq) + $unsigned(o2_sq);
            c0_reg <= c;
        end
    end

    // square root of sq*2^32, one root bit per stage
    logic [RW-1:0]                       rem_reg [1:RB];
    logic [RB-1:0]                       root_reg [1:RB];
    logic [RW-1:0]                       num_reg [1:RB];
    logic signed [tilt_pkg::ACCEL_W-1:0] cs_reg [1:RB];

    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        logic [RW-1:0]                       rem_in;
        logic [RB-1:0]                       root_in;
        logic [RW-1:0]                       num_in;
        logic signed [tilt_pkg::ACCEL_W-1:0] cs_in;
        logic [RW-1:0]                       r2;
        logic [RW-1:0]                       trial;
        if (k == 0) begin : g_head
            assign rem_in  = '0;
            assign root_in = '0;
            assign num_in  = {{(RW-tilt_pkg::SQ_W-32){1'b0}}, sq_reg, 32'd0};
            assign cs_in   = c0_reg;
        end
        else begin : g_tail
            assign rem_in  = rem_reg[k];
            assign root_in = root_reg[k];
            assign num_in  = num_reg[k];
            assign cs_in   = cs_reg[k];
        end
        assign r2    = {rem_in[RW-3:0], num_in[RW-1:RW-2]};
        assign trial = RW'({root_in, 2'b01});
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (r2 >= trial)
                begin
                    rem_reg[k+1]  <= r2 - trial;
                    root_reg[k+1] <= {root_in[RB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1]  <= r2;
                    root_reg[k+1] <= {root_in[RB-2:0], 1'b0};
                end
                num_reg[k+1] <= {num_in[RW-3:0], 2'b00};
                cs_reg[k+1]  <= cs_in;
            end
        end
    end

    // CORDIC vectoring
    logic signed [CW-1:0] x_reg [STEPS+1];
    logic signed [CW-1:0] y_reg [STEPS+1];
    logic signed [ZW-1:0] z_reg [STEPS+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (cs_reg[RB] < 0)
            begin
                x_reg[0] <= CW'($signed({1'b0, root_reg[RB]}));
                y_reg[0] <= -(CW'(cs_reg[RB]) <<< 16);
                z_reg[0] <= ZW'($signed({1'b0, tilt_pkg::RAD_HALF_PI}));
            end
            else
            begin
                x_reg[0] <= CW'(cs_reg[RB]) <<< 16;
                y_reg[0] <= CW'($signed({1'b0, root_reg[RB]}));
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_cordic
        localparam int SH = (i > SHMAX) ? SHMAX : i;
        localparam logic [tilt_pkg::RAD_W-1:0] AT = tilt_pkg::atan_step(i);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> SH);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> SH);
                    z_reg[i+1] <= z_reg[i] + ZW'($signed({1'b0, AT}));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> SH);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> SH);
                    z_reg[i+1] <= z_reg[i] - ZW'($signed({1'b0, AT}));
                end
            end
        end
    end

    // clamp, scale, round
    logic [tilt_pkg::RAD_W-1:0] zc_reg;
    logic [MW-1:0]              m_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (z_reg[STEPS] < 0)
                zc_reg <= '0;
            else if (z_reg[STEPS] > ZW'($signed({1'b0, tilt_pkg::RAD_PI})))
                zc_reg <= tilt_pkg::RAD_PI;
            else
                zc_reg <= tilt_pkg::RAD_W'(z_reg[STEPS]);
            m_reg <= MW'(zc_reg) * MW'(5729);
        end
    end

    localparam logic [MW+FRAC-1:0] DEN = (MW+FRAC)'(100) << 30;
    logic [MW+FRAC-1:0] num;
    assign num = ((MW+FRAC)'(m_reg) << FRAC) + (DEN >> 1);
    // divide by 100*2^30: shift 32, then by 25
    logic [TW-1:0] t;
    assign t = num[MW+FRAC-1:32];

    logic [TW-1:0] t_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            t_reg <= t;
    end

    // reciprocal of 25 is exact for t below 2^30
    logic [TW+28:0] prod;
    assign prod = (TW+29)'(t_reg) * (TW+29)'(RECIP25);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            angle <= '0;
        else if (adv)
            angle <= AW'(prod[TW+28:32]);
    end
endmodule

FILE: tb/tb_accel_tilt_angles.sv
// tb_accel_tilt_angles: self-checking testbench for accel_tilt_angles.
// Depends on tilt_pkg and accel_tilt_angles; directed table, then random samples,
// each output beat checked against a typed expectation or a built-in angle predictor.
`timescale 1ns / 1ps
module tb_accel_tilt_angles;

    localparam int FRAC_BITS  = 7;
    localparam int CORDIC_N   = 16;
    localparam int LIMIT      = 200000;
    localparam int DRAIN      = 80;
    localparam longint HALF_PI_RAD = 64'd1686629713;
    localparam longint PI_RAD      = 64'd3373259426;
    localparam longint ATAN_LUT [10] = '{
        843314856, 497837829, 263043836, 133525158, 67021686,
        33543515, 16775850, 8388437, 4194282, 2097149
    };

    typedef struct {
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [15:0] tz;
        logic               zv;
    } tilt_t;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        bit                 typed;
        tilt_t              want;
    } stim_row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic cfg_wdata = 0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [15:0] accel_x = 0;
    logic signed [15:0] accel_y = 0;
    logic signed [15:0] accel_z = 0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [15:0] tilt_x;
    logic signed [15:0] tilt_y;
    logic signed [15:0] tilt_z;
    logic zero_vector;

    tilt_t pending_tilts[$];
    bit    z_mode = 0;
    int    send_idle_pct = 0;
    int    stall_pct = 0;
    int    errors = 0;
    int    cycles = 0;

    accel_tilt_angles #(.ANGLE_FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_N)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .tilt_x(tilt_x), .tilt_y(tilt_y), .tilt_z(tilt_z),
        .zero_vector(zero_vector)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // acos(c/R) in 1/2^FRAC_BITS degree via isqrt + CORDIC vectoring
    function automatic longint axis_deg(longint c, longint o1, longint o2);
        longint unsigned sq;
        longint unsigned num;
        longint unsigned den;
        longint s, cc, x, y, z, nx, ny, step;
        sq = o1 * o1 + o2 * o2;
        s = int_sqrt(sq << 32);
        cc = c * 65536;
        if (cc < 0)
        begin
            x = s;
            y = -cc;
            z = HALF_PI_RAD;
        end
        else
        begin
            x = cc;
            y = s;
            z = 0;
        end
        for (int i = 0; i < CORDIC_N; i++)
        begin
            if (i < 10)
                step = ATAN_LUT[i];
            else if (i < 30)
                step = (64'sd1 <<< (30 - i)) - 1;
            else
                step = 0;
            if (y > 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + step;
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - step;
            end
            x = nx;
            y = ny;
        end
        if (z < 0)
            z = 0;
        if (z > PI_RAD)
            z = PI_RAD;
        den = 64'd100 << 30;
        num = longint'(z) * 5729 * (64'd1 << FRAC_BITS);
        return longint'((num + den / 2) / den);
    endfunction

    function automatic tilt_t predict_tilt(logic signed [15:0] ax, logic signed [15:0] ay,
                                           logic signed [15:0] az, bit mode);
        tilt_t r;
        longint x, y, z, tx, ty, tz;
        x = ax;
        y = ay;
        z = az;
        if (x == 0 && y == 0 && z == 0)
        begin
            r = '{0, 0, 0, 1'b1};
            return r;
        end
        tx = axis_deg(x, y, z);
        ty = axis_deg(y, x, z);
        tz = axis_deg(z, x, y);
        if (z < 0)
        begin
            tx = -tx;
            ty = -ty;
        end
        tx = tx - (90 << FRAC_BITS);
        if (tx < -(180 << FRAC_BITS))
            tx = tx + (360 << FRAC_BITS);
        ty = ty - (90 << FRAC_BITS);
        if (ty < -(180 << FRAC_BITS))
            ty = ty + (360 << FRAC_BITS);
        if (mode && tx < 0)
            tz = -tz;
        r.tx = tx[15:0];
        r.ty = ty[15:0];
        r.tz = tz[15:0];
        r.zv = 1'b0;
        return r;
    endfunction

    task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az, bit typed, tilt_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        accel_x <= ax;
        accel_y <= ay;
        accel_z <= az;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_tilts.push_back(typed ? want : predict_tilt(ax, ay, az, z_mode));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_tilts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(bit v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        z_mode = v;
    endtask

    task automatic random_beats(int n);
        logic signed [15:0] v [3];
        tilt_t none;
        none = '{0, 0, 0, 1'b0};
        repeat (n)
        begin
            case ($urandom_range(3))
                0: foreach (v[k]) v[k] = 16'($urandom);
                1: foreach (v[k]) v[k] = 16'($urandom_range(127) - 64);
                2:
                begin
                    foreach (v[k]) v[k] = 16'($urandom_range(511) - 256);
                    v[$urandom_range(2)] = 16'($urandom);
                end
                default:
                begin
                    foreach (v[k]) v[k] = 16'($urandom);
                    v[$urandom_range(2)] = '0;
                    if ($urandom_range(1))
                        v[$urandom_range(2)] = '0;
                end
            endcase
            send_sample(v[0], v[1], v[2], 1'b0, none);
        end
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        tilt_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_tilts.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat tx=%0d ty=%0d tz=%0d zv=%0b",
                         $time, tilt_x, tilt_y, tilt_z, zero_vector);
            end
            else
            begin
                want = pending_tilts.pop_front();
                if (tilt_x !== want.tx)
                begin
                    errors++;
                    $display("%0t: tilt_x exp %0d got %0d", $time, want.tx, tilt_x);
                end
                if (tilt_y !== want.ty)
                begin
                    errors++;
                    $display("%0t: tilt_y exp %0d got %0d", $time, want.ty, tilt_y);
                end
                if (tilt_z !== want.tz)
                begin
                    errors++;
                    $display("%0t: tilt_z exp %0d got %0d", $time, want.tz, tilt_z);
                end
                if (zero_vector !== want.zv)
                begin
                    errors++;
                    $display("%0t: zero_vector exp %0b got %0b", $time, want.zv, zero_vector);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    stim_row_t stim_table [] = '{
        '{16'sd0,      16'sd0,      16'sd0,      1'b1, '{0, 0, 0, 1'b1}},
        '{16'sd0,      16'sd0,      16'sd1000,   1'b0, '{0, 0, 0, 1'b0}},
        '{16'sd0,      16'sd0,      -16'sd1000,  1'b0, '{0, 0, 0, 1'b0}},
        '{16'sd32767,  16'sd0,      16'sd0,      1'b0, '{0, 0, 0, 1'b0}},
        '{-16'sd32768, 16'sd0,      16'sd0,      1'b0, '{0, 0, 0, 1'b0}},
        '{16'sd0,      16'sd32767,  16'sd0,      1'b0, '{0, 0, 0, 1'b0}},
        '{16'sd0,      -16'sd32768, 16'sd0,      1'b0, '{0, 0, 0, 1'b0}},
        '{16'sd0,      16'sd0,      16'sd32767,  1'b0, '{0, 0, 0, 1'b0}},
        '{16'sd0,      16'sd0,      -16'sd32768, 1'b0, '{0, 0, 0, 1'b0}},
        '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, '{0, 0, 0, 1'b0}},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '{0, 0, 0, 1'b0}},
        '{-16'sd32768, 16'sd0,      -16'sd1,     1'b0, '{0, 0, 0, 1'b0}},
        '{16'sd0,      -16'sd32768, -16'sd1,     1'b0, '{0, 0, 0, 1'b0}},
        '{16'sd0,      16'sd500,    -16'sd500,   1'b0, '{0, 0, 0, 1'b0}},
        '{16'sd1,      16'sd0,      16'sd0,      1'b0, '{0, 0, 0, 1'b0}},
        '{-16'sd1,     -16'sd1,     16'sd1,      1'b0, '{0, 0, 0, 1'b0}},
        '{-16'sd20000, 16'sd100,    16'sd9000,   1'b0, '{0, 0, 0, 1'b0}},
        '{16'sd20000,  -16'sd100,   -16'sd9000,  1'b0, '{0, 0, 0, 1'b0}},
        '{-16'sd32768, 16'sd32767,  -16'sd32768, 1'b0, '{0, 0, 0, 1'b0}},
        '{16'sd0,      16'sd0,      16'sd0,      1'b1, '{0, 0, 0, 1'b1}}
    };

    initial
    begin
        int waited;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 35;
        stall_pct = 64;
        foreach (stim_table[r])
            send_sample(stim_table[r].ax, stim_table[r].ay, stim_table[r].az,
                        stim_table[r].typed, stim_table[r].want);
        write_mode(1'b1);
        foreach (stim_table[r])
            send_sample(stim_table[r].ax, stim_table[r].ay, stim_table[r].az,
                        stim_table[r].typed, stim_table[r].want);
        random_beats(110);

        write_mode(1'b0);
        send_idle_pct = 64;
        stall_pct = 35;
        random_beats(120);

        write_mode(1'b1);
        send_idle_pct = 0;
        stall_pct = 0;
        random_beats(130);

        in_valid <= 1'b0;
        waited = 0;
        while (pending_tilts.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN) @(posedge clk);
        if (errors == 0 && pending_tilts.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
